// ===== design/mm4_pkg.sv =====
// Shared constants for the 4x4 fixed-point matrix multiplier.
`default_nettype none
package mm4_pkg;
    localparam int DATA_W      = 32;  // Q16.16 element width
    localparam int FRAC_W      = 16;  // fractional bits
    localparam int OUT_IDX_W   = 2;   // width of c_row / c_col
    localparam int DIM_DEFAULT = 4;   // matrix dimension
endpackage : mm4_pkg
`default_nettype wire

// ===== design/matrix_multiply_4x4.sv =====
// DIM x DIM signed Q16.16 matrix multiplier with memory-backed operand stores.
// Loads: one transaction per cycle while busy is low; element i of A and B goes to entry i.
// After the final load, busy rises and the single MAC walks every row, col and k step.
// Each result strobes valid once its last k step has passed the read, product and accumulate stages.
// A 4x4 product therefore needs 16 loads before compute starts.
// Reset (rst_n low, async) clears the load counter, sequencer and valid flags; stores hold old data.
`default_nettype none
module matrix_multiply_4x4
    import mm4_pkg::*;
#(
    parameter int DIM = DIM_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [DATA_W-1:0] a_value,
    input  wire logic signed [DATA_W-1:0] b_value,
    output logic                          valid,
    output logic signed [DATA_W-1:0]      c_value,
    output logic [OUT_IDX_W-1:0]          c_row,
    output logic [OUT_IDX_W-1:0]          c_col,
    output logic                          last
);
    localparam int CELLS  = DIM * DIM;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int IDX_W  = $clog2(DIM);
    localparam int PROD_W = 2 * DATA_W;
    localparam int EXT_W  = $clog2(DIM);          // growth of a DIM-term sum
    localparam int ACC_W  = PROD_W + EXT_W;
    localparam int SH_W   = ACC_W - FRAC_W;       // width after dropping fraction
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(DIM - 1);
    localparam logic [DATA_W-1:0] SAT_POS   = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_NEG   = {1'b1, {(DATA_W-1){1'b0}}};

    // Operand stores: one write port (load), one read port (compute) each
    logic [DATA_W-1:0] a_mem [CELLS];
    logic [DATA_W-1:0] b_mem [CELLS];

    logic              load_fire;
    logic [ADDR_W-1:0] load_cnt_reg, load_cnt_next;

    // Sequencer: row / col / k walk every MAC step
    logic              run_reg, run_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [ADDR_W-1:0] a_addr, b_addr;

    // Stage 1: read data
    logic                     s1_v_reg;
    logic                     s1_first_reg, s1_last_reg;
    logic [IDX_W-1:0]         s1_row_reg, s1_col_reg;
    logic signed [DATA_W-1:0] rd_a_reg, rd_b_reg;

    // Stage 2: product
    logic                     s2_v_reg;
    logic                     s2_first_reg, s2_last_reg;
    logic [IDX_W-1:0]         s2_row_reg, s2_col_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // Stage 3: accumulate, floor, saturate
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  acc_base;
    logic [SH_W-1:0]   sh;
    logic              fits;
    logic [DATA_W-1:0] sat_val;

    logic                     valid_reg;
    logic [DATA_W-1:0]        c_value_reg;
    logic [OUT_IDX_W-1:0]     c_row_reg, c_col_reg;
    logic                     last_reg;

    assign busy      = run_reg | s1_v_reg | s2_v_reg;
    assign load_fire = start & ~busy;

    // ---------------- load path ----------------
    always_comb
    begin
        load_cnt_next = load_cnt_reg;
        if (load_fire)
        begin
            if (load_cnt_reg == LAST_CELL)
                load_cnt_next = '0;
            else
                load_cnt_next = load_cnt_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            a_mem[load_cnt_reg] <= a_value;
            b_mem[load_cnt_reg] <= b_value;
        end
    end

    // ---------------- sequencer ----------------
    // A[row][k] and B[k][col]; products fit since both are below CELLS
    assign a_addr = ADDR_W'(row_reg) * ADDR_W'(DIM) + ADDR_W'(k_reg);
    assign b_addr = ADDR_W'(k_reg) * ADDR_W'(DIM) + ADDR_W'(col_reg);

    always_comb
    begin
        run_next = run_reg;
        row_next = row_reg;
        col_next = col_reg;
        k_next   = k_reg;
        if (run_reg)
        begin
            if (k_reg != LAST_IDX)
                k_next = k_reg + IDX_W'(1);
            else
            begin
                k_next = '0;
                if (col_reg != LAST_IDX)
                    col_next = col_reg + IDX_W'(1);
                else
                begin
                    col_next = '0;
                    if (row_reg != LAST_IDX)
                        row_next = row_reg + IDX_W'(1);
                    else
                    begin
                        row_next = '0;
                        run_next = 1'b0;
                    end
                end
            end
        end
        else if (load_fire && load_cnt_reg == LAST_CELL)
            run_next = 1'b1;
    end

    // synchronous read into rd_a_reg / rd_b_reg
    always_ff @(posedge clk)
    begin
        if (run_reg)
        begin
            rd_a_reg <= a_mem[a_addr];
            rd_b_reg <= b_mem[b_addr];
        end
    end

    // ---------------- accumulate ----------------
    assign acc_base = s2_first_reg ? '0 : acc_reg;
    assign acc_next = acc_base + {{EXT_W{prod_reg[PROD_W-1]}}, prod_reg};
    // arithmetic drop of the fraction is floor toward minus infinity
    assign sh       = acc_next[ACC_W-1:FRAC_W];
    assign fits     = (&sh[SH_W-1:DATA_W-1]) | ~(|sh[SH_W-1:DATA_W-1]);
    assign sat_val  = fits ? sh[DATA_W-1:0] : (sh[SH_W-1] ? SAT_NEG : SAT_POS);

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg <= '0;
            run_reg      <= 1'b0;
            row_reg      <= '0;
            col_reg      <= '0;
            k_reg        <= '0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            load_cnt_reg <= load_cnt_next;
            run_reg      <= run_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            k_reg        <= k_next;
            s1_v_reg     <= run_reg;
            s2_v_reg     <= s1_v_reg;
            valid_reg    <= s2_v_reg & s2_last_reg;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        s1_first_reg <= (k_reg == '0);
        s1_last_reg  <= (k_reg == LAST_IDX);
        s1_row_reg   <= row_reg;
        s1_col_reg   <= col_reg;

        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_row_reg   <= s1_row_reg;
        s2_col_reg   <= s1_col_reg;
        prod_reg     <= rd_a_reg * rd_b_reg;

        if (s2_v_reg)
            acc_reg <= acc_next;

        c_value_reg <= sat_val;
        c_row_reg   <= OUT_IDX_W'(s2_row_reg);
        c_col_reg   <= OUT_IDX_W'(s2_col_reg);
        last_reg    <= (s2_row_reg == LAST_IDX) && (s2_col_reg == LAST_IDX);
    end

    assign valid   = valid_reg;
    assign c_value = c_value_reg;
    assign c_row   = c_row_reg;
    assign c_col   = c_col_reg;
    assign last    = last_reg;

endmodule : matrix_multiply_4x4
`default_nettype wire
